/* hdl/kmrd_pkg.sv */
package kmrd_pkg;

    localparam int ROWS = 8;
    localparam int COLS = 16;

    localparam int ROW_W    = 4;
    localparam int COL_W    = 16;
    localparam int TICK_W   = 8;
    localparam int ROW_AW   = (ROWS > 1) ? $clog2(ROWS) : 1;

    localparam int IN_DATA_W  = ((ROW_W + COL_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((ROW_W + 2 * COL_W + 7) / 8) * 8;

    localparam logic [TICK_W-1:0] DEBOUNCE_RESET = TICK_W'(3);

    typedef logic [TICK_W-1:0] tick_t;

    typedef struct packed {
        logic [COL_W-1:0]            bits;
        logic [COLS-1:0][TICK_W-1:0] cnt;
    } row_rec_t;

    typedef struct packed {
        logic              we;
        logic [ROW_AW-1:0] addr;
        row_rec_t          rec;
    } row_wr_t;

endpackage

/* hdl/kmrd_row_store.sv */
module kmrd_row_store
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [kmrd_pkg::ROW_AW-1:0]   rd_addr,
    output kmrd_pkg::row_rec_t            rd_rec,
    input  kmrd_pkg::row_wr_t             wr
);

    kmrd_pkg::row_rec_t rows_reg [kmrd_pkg::ROWS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < kmrd_pkg::ROWS; r++)
            begin
                rows_reg[r] <= '0;
            end
        end
        else if (wr.we)
        begin
            rows_reg[wr.addr] <= wr.rec;
        end
    end

    assign rd_rec = rows_reg[rd_addr];

endmodule

/* hdl/kmrd_row_update.sv */
module kmrd_row_update
(
    input  logic                          row_ok,
    input  logic [kmrd_pkg::COL_W-1:0]    raw,
    input  kmrd_pkg::tick_t               ticks,
    input  kmrd_pkg::row_rec_t            cur,
    output kmrd_pkg::row_rec_t            nxt,
    output logic [kmrd_pkg::COL_W-1:0]    pressed_now,
    output logic [kmrd_pkg::COL_W-1:0]    pressed_before
);

    logic [kmrd_pkg::COL_W-1:0] now_bits;

    always_comb
    begin
        now_bits = '0;
        nxt      = cur;
        for (int c = 0; c < kmrd_pkg::COLS; c++)
        begin
            if (cur.cnt[c] == '0)
            begin
                now_bits[c] = raw[c];
            end
            else
            begin
                now_bits[c]  = cur.bits[c];
                nxt.cnt[c]   = cur.cnt[c] - kmrd_pkg::TICK_W'(1);
            end
            if (now_bits[c] != cur.bits[c])
            begin
                nxt.cnt[c] = ticks;
            end
        end
        nxt.bits = now_bits;
    end

    assign pressed_now    = row_ok ? now_bits : '0;
    assign pressed_before = row_ok ? cur.bits : '0;

endmodule

/* hdl/key_matrix_row_debouncer.sv */
// a result passes through the input register and then the output register before it is offered
// throughput: one transaction per cycle unless the output stalls, the row state is read
//   and written back in the cycle an item leaves the input register, so back-to-back rows chain
// reset: asynchronous, clears all debounced bits and hold-off counters,
//   sets debounce_ticks to 3 and empties both stages
module key_matrix_row_debouncer
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [kmrd_pkg::TICK_W-1:0]          cfg_wdata,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // row_index[3:0], raw_columns[19:4], zero pad
    input  logic [kmrd_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // row_out[3:0], pressed_now[19:4], pressed_before[35:20], zero pad
    output logic [kmrd_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);

    localparam int RW = kmrd_pkg::ROW_W;
    localparam int CW = kmrd_pkg::COL_W;

    kmrd_pkg::tick_t             ticks_reg;
    logic                        s1_valid_reg;
    logic [RW-1:0]               s1_row_reg;
    logic [CW-1:0]               s1_raw_reg;
    logic                        out_valid_reg;
    logic [RW-1:0]               out_row_reg;
    logic [CW-1:0]               out_now_reg;
    logic [CW-1:0]               out_before_reg;

    logic                        s1_advance;
    logic                        in_take;
    logic                        row_ok;
    kmrd_pkg::row_rec_t          cur_rec;
    kmrd_pkg::row_rec_t          nxt_rec;
    kmrd_pkg::row_wr_t           wr;
    logic [CW-1:0]               now_bits;
    logic [CW-1:0]               before_bits;

    assign s1_advance    = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign row_ok        = ({1'b0, s1_row_reg} < (RW + 1)'(kmrd_pkg::ROWS));

    assign wr.we   = s1_advance && row_ok;
    assign wr.addr = s1_row_reg[kmrd_pkg::ROW_AW-1:0];
    assign wr.rec  = nxt_rec;

    kmrd_row_store u_store
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (s1_row_reg[kmrd_pkg::ROW_AW-1:0]),
        .rd_rec  (cur_rec),
        .wr      (wr)
    );

    kmrd_row_update u_update
    (
        .row_ok         (row_ok),
        .raw            (s1_raw_reg),
        .ticks          (ticks_reg),
        .cur            (cur_rec),
        .nxt            (nxt_rec),
        .pressed_now    (now_bits),
        .pressed_before (before_bits)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg     <= kmrd_pkg::DEBOUNCE_RESET;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                ticks_reg <= cfg_wdata;
            end
            if (s_axis_tready)
            begin
                s1_valid_reg <= s_axis_tvalid;
            end
            if (s1_advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_row_reg <= s_axis_tdata[RW-1:0];
            s1_raw_reg <= s_axis_tdata[RW+CW-1:RW];
        end
        if (s1_advance)
        begin
            out_row_reg    <= s1_row_reg;
            out_now_reg    <= now_bits;
            out_before_reg <= before_bits;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = kmrd_pkg::OUT_DATA_W'({out_before_reg, out_now_reg, out_row_reg});

endmodule

/* hdl/kmrd_checker.sv */
module kmrd_checker
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    input  logic                                 s_axis_tready,
    input  logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    input  logic [kmrd_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);

    localparam int RW = kmrd_pkg::ROW_W;
    localparam int CW = kmrd_pkg::COL_W;

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // rows outside the matrix report no keys
    a_bad_row: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && ({1'b0, m_axis_tdata[RW-1:0]} >= (RW + 1)'(kmrd_pkg::ROWS))
        |-> m_axis_tdata[RW+2*CW-1:RW] == '0)
        else $error("out of range row reported keys");

    // with the output empty the input side always takes a transaction
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // no result without a preceding input transaction
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!m_axis_tvalid) && $past(!(s_axis_tvalid && s_axis_tready))
        && $past(s_axis_tready) && $past(!m_axis_tvalid, 2)
        && $past(!(s_axis_tvalid && s_axis_tready), 2) |-> !m_axis_tvalid)
        else $error("result appeared without input");

endmodule

bind key_matrix_row_debouncer kmrd_checker u_kmrd_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* tb/sv/kmrd_checker.sv */
module kmrd_tb_checker
    import kmrd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [TICK_W-1:0]     cfg_wdata,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    // row_index[3:0], raw_columns[19:4], zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // row_out[3:0], pressed_now[19:4], pressed_before[35:20], zero pad
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,
    output int                    mismatches,
    output int                    outstanding
);

    localparam int REPORT_LIMIT = 100;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] now;
        logic [COL_W-1:0] prev;
    } row_result_t;

    tick_t            ticks;
    logic [COL_W-1:0] debounced [ROWS];
    tick_t            holdoff [ROWS][COLS];
    row_result_t      expected_rows [$];
    row_result_t      want;
    row_result_t      got;
    int               results_seen;

    // advance one row scan through the hold-off counters
    function automatic row_result_t debounce_row(logic [ROW_W-1:0] row,
                                                 logic [COL_W-1:0] raw);
        row_result_t r;
        int          idx;
        r.row  = row;
        r.now  = '0;
        r.prev = '0;
        idx    = int'(row);
        if (idx < ROWS)
        begin
            r.prev = debounced[idx];
            for (int c = 0; c < COL_W; c++)
            begin
                if (c < COLS)
                begin
                    if (holdoff[idx][c] != '0)
                    begin
                        holdoff[idx][c] = holdoff[idx][c] - 1'b1;
                        r.now[c] = r.prev[c];
                    end
                    else
                    begin
                        r.now[c] = raw[c];
                    end
                    if (r.now[c] != r.prev[c])
                        holdoff[idx][c] = ticks;
                end
            end
            debounced[idx] = r.now;
        end
        return r;
    endfunction

    task automatic report(input string msg);
        if (mismatches < REPORT_LIMIT)
            $display("mismatch: %s", msg);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks = DEBOUNCE_RESET;
            for (int r = 0; r < ROWS; r++)
            begin
                debounced[r] = '0;
                for (int c = 0; c < COLS; c++)
                    holdoff[r][c] = '0;
            end
            expected_rows.delete();
            results_seen = 0;
        end
        else
        begin
            if (cfg_we)
                ticks = cfg_wdata;
            if (s_axis_tvalid && s_axis_tready)
                expected_rows.push_back(debounce_row(s_axis_tdata[ROW_W-1:0],
                                                     s_axis_tdata[ROW_W +: COL_W]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.row  = m_axis_tdata[ROW_W-1:0];
                got.now  = m_axis_tdata[ROW_W +: COL_W];
                got.prev = m_axis_tdata[ROW_W + COL_W +: COL_W];
                if (expected_rows.size() == 0)
                begin
                    report($sformatf("result %0d (row %0d) with no scan pending",
                                     results_seen, got.row));
                end
                else
                begin
                    want = expected_rows.pop_front();
                    if (got.row !== want.row)
                        report($sformatf("result %0d row_out %h, expected %h",
                                         results_seen, got.row, want.row));
                    if (got.now !== want.now)
                        report($sformatf("result %0d row %0d pressed_now %h, expected %h",
                                         results_seen, want.row, got.now, want.now));
                    if (got.prev !== want.prev)
                        report($sformatf("result %0d row %0d pressed_before %h, expected %h",
                                         results_seen, want.row, got.prev, want.prev));
                end
                results_seen++;
            end
        end
        outstanding <= expected_rows.size();
    end

endmodule

/* tb/sv/tb.sv */
module tb;

    import kmrd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_SLACK    = 4;

    typedef enum logic [1:0] {
        RX_STREAM,
        RX_RANDOM,
        RX_SPARSE,
        RX_LONG_STALL
    } rx_mode_t;

    logic                  clk;
    logic                  rst_n         = 1'b0;
    logic                  cfg_we        = 1'b0;
    logic [TICK_W-1:0]     cfg_wdata     = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // row_index[3:0], raw_columns[19:4], zero pad
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // row_out[3:0], pressed_now[19:4], pressed_before[35:20], zero pad
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    int       errors;
    int       outstanding;
    int       burst_left;
    int       scans_sent;
    int       stray_scans;
    int       settings_used;
    int       quiet_cycles;
    rx_mode_t rx_mode   = RX_STREAM;
    int       mode_left;
    logic [7:0] rx_phase = '0;
    logic [COL_W-1:0] key_truth [ROWS] = '{default: '0};

    key_matrix_row_debouncer dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    kmrd_tb_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .mismatches    (errors),
        .outstanding   (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver backpressure
    always @(posedge clk)
    begin
        rx_phase <= rx_phase + 1'b1;
        if (mode_left == 0)
        begin
            rx_mode   <= rx_mode_t'($urandom_range(0, 3));
            mode_left <= $urandom_range(50, 150);
        end
        else
        begin
            mode_left <= mode_left - 1;
        end
        case (rx_mode)
            RX_STREAM:   m_axis_tready <= 1'b1;
            RX_RANDOM:   m_axis_tready <= ($urandom_range(0, 9) < 7);
            RX_SPARSE:   m_axis_tready <= (rx_phase[1:0] == 2'd0);
            default:     m_axis_tready <= (rx_phase[4:0] > 5'd24);
        endcase
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_scan(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] raw);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_DATA_W'({raw, row});
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        burst_left--;
        scans_sent++;
        if (int'(row) >= ROWS)
            stray_scans++;
    endtask

    // hold off until every expected result has come back
    task automatic drain_stream();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    task automatic write_ticks(input tick_t value);
        drain_stream();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        settings_used++;
    endtask

    // bouncy key presses on a few live rows plus stray full-random scans
    task automatic run_phase(input tick_t value, input int items, input int rows_live);
        int               base;
        int               r;
        logic [COL_W-1:0] bounce;
        write_ticks(value);
        base = $urandom_range(0, ROWS - 1);
        for (int i = 0; i < items; i++)
        begin
            if (i == items / 2)
                drain_stream();
            if ($urandom_range(0, 9) == 0)
            begin
                send_scan(ROW_W'($urandom_range(0, 15)), COL_W'($urandom));
            end
            else
            begin
                r = (base + $urandom_range(0, rows_live - 1)) % ROWS;
                if ($urandom_range(0, 5) == 0)
                    key_truth[r] ^= COL_W'(1) << $urandom_range(0, COL_W - 1);
                else if ($urandom_range(0, 19) == 0)
                    key_truth[r] ^= COL_W'($urandom & $urandom);
                bounce = ($urandom_range(0, 2) == 0) ? COL_W'($urandom & $urandom & $urandom)
                                                     : '0;
                send_scan(ROW_W'(r), key_truth[r] ^ bounce);
            end
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset debounce count of 3
        send_scan(4'd0, 16'hFFFF);
        repeat (5) send_scan(4'd0, 16'h0000);
        send_scan(4'd7, 16'hA5A5);
        send_scan(4'd7, 16'h5A5A);
        send_scan(4'd8, 16'hFFFF);
        send_scan(4'd15, 16'hFFFF);
        send_scan(4'd3, 16'h8001);
        send_scan(4'd3, 16'h0001);

        // zero debounce, every read taken
        write_ticks(8'd0);
        send_scan(4'd1, 16'hFFFF);
        send_scan(4'd1, 16'h0000);
        send_scan(4'd1, 16'hFFFF);
        send_scan(4'd1, 16'h0000);

        // longest hold-off
        write_ticks(8'd255);
        send_scan(4'd2, 16'hFFFF);
        send_scan(4'd2, 16'h0000);
        send_scan(4'd2, 16'h0000);

        run_phase(8'd1, 250, 4);
        run_phase(8'd0, 250, 8);
        run_phase(8'd2, 250, 2);
        run_phase(8'd255, 350, 1);
        run_phase(tick_t'($urandom_range(4, 40)), 250, 3);
        run_phase(8'd3, 250, 8);

        drain_stream();
        $display("covered %0d row scans, %0d of them on rows past the matrix,", scans_sent,
                 stray_scans);
        $display("across %0d debounce settings including 0 and 255", settings_used);
        if (errors == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* key_matrix_row_debouncer.f */
hdl/kmrd_pkg.sv
hdl/kmrd_row_store.sv
hdl/kmrd_row_update.sv
hdl/key_matrix_row_debouncer.sv
hdl/kmrd_checker.sv
tb/sv/kmrd_checker.sv
tb/sv/tb.sv
